>>> src/consensus_background_pixel_assert.svh
// Assertion helpers for the consensus background pixel block, included by consensus_background_pixel.sv.
`ifndef CONSENSUS_BACKGROUND_PIXEL_ASSERT_SVH
`define CONSENSUS_BACKGROUND_PIXEL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is asserted.
`define CBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("consensus background pixel check failed");

// Next-cycle implication, sampled on the rising clock edge, off while reset is asserted.
`define CBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("consensus background pixel check failed");

`endif

>>> src/cbp_pkg.sv
`timescale 1ns / 1ps
package cbp_pkg;

    localparam int MAX_IMAGES = 64;
    localparam int CHANNELS   = 3;
    localparam int NUM_FIELDS = 3;
    localparam int USED_CH    = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int IDX_W      = $clog2(MAX_IMAGES);
    localparam int ROWS       = MAX_IMAGES / LANES;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = CHAN_W + IDX_W;
    localparam int DIV_W      = 16;
    localparam int THR_W      = 9;
    localparam int LIM_W      = 2 * THR_W;
    localparam int MINI_W     = 7;
    localparam int ATT_W      = 4;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INLIERS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED      = 2'd3;

    localparam logic [THR_W-1:0]  RST_DIST_THRESHOLD = 9'd30;
    localparam logic [MINI_W-1:0] RST_MIN_INLIERS    = 7'd3;
    localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPTS   = 4'd10;
    localparam logic [LFSR_W-1:0] RST_LFSR_SEED      = 16'd44257;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_FIELDS-1:0] sample_t;

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b00_0000_0001,
        ST_CHECK  = 10'b00_0000_0010,
        ST_MOD    = 10'b00_0000_0100,
        ST_PLATCH = 10'b00_0000_1000,
        ST_SCAN   = 10'b00_0001_0000,
        ST_EVAL   = 10'b00_0010_0000,
        ST_SUMS   = 10'b00_0100_0000,
        ST_DIVS   = 10'b00_1000_0000,
        ST_DIVW   = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    // Galois LFSR step, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

>>> src/cbp_sample_if.sv
`timescale 1ns / 1ps
interface cbp_sample_if;
    import cbp_pkg::*;
    logic  valid;
    logic  ready;
    chan_t sample_c0;
    chan_t sample_c1;
    chan_t sample_c2;
    logic  last_sample;

    modport source (output valid, sample_c0, sample_c1, sample_c2, last_sample, input ready);
    modport sink (input valid, sample_c0, sample_c1, sample_c2, last_sample, output ready);
endinterface

>>> src/cbp_result_if.sv
`timescale 1ns / 1ps
interface cbp_result_if;
    import cbp_pkg::*;
    logic             valid;
    logic             ready;
    chan_t            mean_c0;
    chan_t            mean_c1;
    chan_t            mean_c2;
    logic [CNT_W-1:0] inlier_count;

    modport source (output valid, mean_c0, mean_c1, mean_c2, inlier_count, input ready);
    modport sink (input valid, mean_c0, mean_c1, mean_c2, inlier_count, output ready);
endinterface

>>> src/cbp_cfg_if.sv
`timescale 1ns / 1ps
interface cbp_cfg_if;
    import cbp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/consensus_background_pixel.sv
`timescale 1ns / 1ps
// Consensus background pixel. Samples of one pixel position arrive on the sample channel,
// one RGB value per transaction; last_sample closes the set. Up to 64 samples are kept,
// later ones are dropped. Once the set is closed the block runs random picks from a 16-bit
// LFSR and counts, for each pick, the samples that lie within the distance threshold; the
// largest such set is kept. The result channel then carries one transaction with the
// truncated channel means of that set and its size. Registers are written on the config
// channel (index 0 threshold, 1 min inliers, 2 max attempts, 3 LFSR seed); the user must
// write them only while idle, which the block does not enforce. Each attempt runs the
// serial modulo that turns the LFSR into an index, the pick fetch, and one pass over the
// four-lane scan of the sample memory. The mean pass runs the scan and then the 16-step
// serial dividers; short sets cost far more per sample. One set is processed at a time.
// Reset returns the registers to their defaults, loads the LFSR with the default seed and
// empties the set. If the receiver stalls, the result waits in its output register; the
// next set may load and run its search, but its result is held until that one is taken.
module consensus_background_pixel (
    input  logic          clk,
    input  logic          rst_n,
    cbp_sample_if.sink    sample,
    cbp_result_if.source  result,
    cbp_cfg_if.sink       cfg
);
    import cbp_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   best_size_reg, best_size_next;
    logic [ATT_W-1:0]   attempt_reg, attempt_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic [THR_W-1:0]   thr_reg;
    logic [MINI_W-1:0]  min_reg;
    logic [ATT_W-1:0]   max_att_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic [CNT_W-1:0]   cur_cnt_reg, cur_cnt_next;
    logic [MAX_IMAGES-1:0] cur_mask_reg, cur_mask_next;
    logic [MAX_IMAGES-1:0] best_mask_reg, best_mask_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   pick_idx_reg, pick_idx_next;
    sample_t            pick_reg, pick_next;
    logic [SUM_W-1:0]   sum_reg [NUM_FIELDS];
    logic [SUM_W-1:0]   sum_next [NUM_FIELDS];
    logic               res_valid_reg, res_valid_next;
    chan_t              mean_reg [NUM_FIELDS];
    chan_t              mean_next [NUM_FIELDS];
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    // Sample memory: one bank per lane, sample i lives in bank i mod 4, row i / 4.
    logic [ROW_W-1:0]   rd_row;
    logic               store_we;
    sample_t            rdata [LANES];
    logic [LANES-1:0]   lane_hit;
    logic [LANES-1:0]   lane_in;

    logic               in_accept;
    logic               out_accept;
    logic [CNT_W-1:0]   count_m1;
    logic [ROW_W-1:0]   last_row;
    logic               go_attempt;

    // Dividers: lane 0 also serves the modulo that maps the LFSR to an index.
    logic               div_start [NUM_FIELDS];
    logic [DIV_W-1:0]   div_dividend [NUM_FIELDS];
    logic [CNT_W-1:0]   div_divisor [NUM_FIELDS];
    logic               div_done [NUM_FIELDS];
    logic [DIV_W-1:0]   div_quot [NUM_FIELDS];
    logic [CNT_W-1:0]   div_rem [NUM_FIELDS];

    assign in_accept    = sample.valid && sample.ready;
    assign out_accept   = result.valid && result.ready;
    assign sample.ready = (state_reg == ST_LOAD);
    assign cfg.ready    = 1'b1;
    assign store_we     = in_accept && (count_reg < CNT_W'(MAX_IMAGES));
    assign count_m1     = count_reg - 1'b1;
    assign last_row     = count_m1[IDX_W-1:LANE_W];
    assign go_attempt   = (best_size_reg < min_reg) && (attempt_reg < max_att_reg);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        cbp_ram #(
            .WIDTH ($bits(sample_t)),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (store_we && (count_reg[LANE_W-1:0] == LANE_W'(l))),
            .waddr (count_reg[IDX_W-1:LANE_W]),
            .wdata ({sample.sample_c2, sample.sample_c1, sample.sample_c0}),
            .raddr (rd_row),
            .rdata (rdata[l])
        );

        assign lane_in[l] = {1'b0, row_reg, LANE_W'(l)} < count_reg;

        cbp_lane u_lane (
            .smp      (rdata[l]),
            .pick     (pick_reg),
            .lim      (lim_reg),
            .in_range (lane_in[l]),
            .hit      (lane_hit[l])
        );
    end

    for (genvar c = 0; c < NUM_FIELDS; c++)
    begin : g_div
        if (c == 0)
        begin : g_mod
            assign div_start[c]    = ((state_reg == ST_CHECK) && go_attempt)
                                     || (state_reg == ST_DIVS);
            assign div_dividend[c] = (state_reg == ST_CHECK) ? lfsr_step(lfsr_reg)
                                                             : DIV_W'(sum_reg[c]);
            assign div_divisor[c]  = (state_reg == ST_CHECK) ? count_reg : best_size_reg;
        end
        else
        begin : g_mean
            assign div_start[c]    = (state_reg == ST_DIVS);
            assign div_dividend[c] = DIV_W'(sum_reg[c]);
            assign div_divisor[c]  = best_size_reg;
        end

        cbp_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (div_start[c]),
            .dividend  (div_dividend[c]),
            .divisor   (div_divisor[c]),
            .done      (div_done[c]),
            .quotient  (div_quot[c]),
            .remainder (div_rem[c])
        );
    end

    // Read row for the cycle after: the pick row, then each scan row in turn.
    always_comb
    begin
        unique case (state_reg)
            ST_MOD:  rd_row = div_rem[0][IDX_W-1:LANE_W];
            ST_SCAN: rd_row = row_reg + 1'b1;
            ST_SUMS: rd_row = row_reg + 1'b1;
            default: rd_row = '0;
        endcase
    end

    always_comb
    begin
        logic [CNT_W-1:0] hits;
        logic [SUM_W-1:0] acc;
        state_next     = state_reg;
        count_next     = count_reg;
        best_size_next = best_size_reg;
        attempt_next   = attempt_reg;
        lfsr_next      = lfsr_reg;
        cur_cnt_next   = cur_cnt_reg;
        cur_mask_next  = cur_mask_reg;
        best_mask_next = best_mask_reg;
        row_next       = row_reg;
        pick_idx_next  = pick_idx_reg;
        pick_next      = pick_reg;
        res_valid_next = res_valid_reg;
        res_cnt_next   = res_cnt_reg;
        hits           = '0;
        for (int c = 0; c < NUM_FIELDS; c++)
        begin
            sum_next[c]  = sum_reg[c];
            mean_next[c] = mean_reg[c];
        end

        if (out_accept)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (sample.last_sample)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (go_attempt)
                begin
                    lfsr_next  = lfsr_step(lfsr_reg);
                    state_next = ST_MOD;
                end
                else
                begin
                    row_next = '0;
                    for (int c = 0; c < NUM_FIELDS; c++)
                    begin
                        sum_next[c] = '0;
                    end
                    state_next = ST_SUMS;
                end
            end
            ST_MOD:
            begin
                if (div_done[0])
                begin
                    pick_idx_next = div_rem[0][IDX_W-1:0];
                    state_next    = ST_PLATCH;
                end
            end
            ST_PLATCH:
            begin
                pick_next    = rdata[pick_idx_reg[LANE_W-1:0]];
                cur_cnt_next = '0;
                row_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    cur_mask_next[{row_reg, LANE_W'(l)}] = lane_hit[l];
                    hits = hits + CNT_W'(lane_hit[l]);
                end
                cur_cnt_next = cur_cnt_reg + hits;
                row_next     = row_reg + 1'b1;
                if (row_reg == last_row)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // Strictly larger wins, so a tie keeps the earlier set.
                if (cur_cnt_reg > best_size_reg)
                begin
                    best_size_next = cur_cnt_reg;
                    best_mask_next = cur_mask_reg;
                end
                attempt_next = attempt_reg + 1'b1;
                state_next   = ST_CHECK;
            end
            ST_SUMS:
            begin
                for (int c = 0; c < USED_CH; c++)
                begin
                    acc = sum_reg[c];
                    for (int l = 0; l < LANES; l++)
                    begin
                        if (lane_in[l] && best_mask_reg[{row_reg, LANE_W'(l)}])
                        begin
                            acc = acc + SUM_W'(rdata[l][c]);
                        end
                    end
                    sum_next[c] = acc;
                end
                row_next = row_reg + 1'b1;
                if (row_reg == last_row)
                begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done[0])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    for (int c = 0; c < NUM_FIELDS; c++)
                    begin
                        mean_next[c] = (best_size_reg == '0 || c >= USED_CH)
                                       ? '0 : div_quot[c][CHAN_W-1:0];
                    end
                    res_cnt_next   = best_size_reg;
                    res_valid_next = 1'b1;
                    count_next     = '0;
                    best_size_next = '0;
                    attempt_next   = '0;
                    best_mask_next = '0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // A seed write loads the generator at once; the user must write only while idle, the block does not enforce it.
        if (cfg.valid && cfg.ready && (cfg.index == CFG_LFSR_SEED))
        begin
            lfsr_next = cfg.data[LFSR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            best_size_reg <= '0;
            attempt_reg   <= '0;
            lfsr_reg      <= RST_LFSR_SEED;
            best_mask_reg <= '0;
            res_valid_reg <= 1'b0;
            thr_reg       <= RST_DIST_THRESHOLD;
            min_reg       <= RST_MIN_INLIERS;
            max_att_reg   <= RST_MAX_ATTEMPTS;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            best_size_reg <= best_size_next;
            attempt_reg   <= attempt_next;
            lfsr_reg      <= lfsr_next;
            best_mask_reg <= best_mask_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_DIST_THRESHOLD: thr_reg     <= cfg.data[THR_W-1:0];
                    CFG_MIN_INLIERS:    min_reg     <= cfg.data[MINI_W-1:0];
                    CFG_MAX_ATTEMPTS:   max_att_reg <= cfg.data[ATT_W-1:0];
                    CFG_LFSR_SEED:      ;
                    default:            ;
                endcase
            end
        end
    end

    // Payload registers. The squared limit is refreshed every cycle from the threshold.
    always_ff @(posedge clk)
    begin
        lim_reg      <= thr_reg * thr_reg;
        cur_cnt_reg  <= cur_cnt_next;
        cur_mask_reg <= cur_mask_next;
        row_reg      <= row_next;
        pick_idx_reg <= pick_idx_next;
        pick_reg     <= pick_next;
        res_cnt_reg  <= res_cnt_next;
        for (int c = 0; c < NUM_FIELDS; c++)
        begin
            sum_reg[c]  <= sum_next[c];
            mean_reg[c] <= mean_next[c];
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.mean_c0      = mean_reg[0];
    assign result.mean_c1      = mean_reg[1];
    assign result.mean_c2      = mean_reg[2];
    assign result.inlier_count = res_cnt_reg;

`include "consensus_background_pixel_assert.svh"

    `CBP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_IMAGES))
    `CBP_ASSERT_IMP(a_best_le_count, clk, rst_n, 1'b1, best_size_reg <= count_reg)
    `CBP_ASSERT_IMP(a_att_bound, clk, rst_n, state_reg != ST_LOAD, attempt_reg <= max_att_reg)
    `CBP_ASSERT_NXT(a_best_update, clk, rst_n,
        (state_reg == ST_EVAL) && (cur_cnt_reg > best_size_reg),
        best_size_reg == $past(cur_cnt_reg))

endmodule

>>> src/cbp_ram.sv
`timescale 1ns / 1ps
module cbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/cbp_lane.sv
`timescale 1ns / 1ps
module cbp_lane (
    input  cbp_pkg::sample_t          smp,
    input  cbp_pkg::sample_t          pick,
    input  logic [cbp_pkg::LIM_W-1:0] lim,
    input  logic                      in_range,
    output logic                      hit
);
    import cbp_pkg::*;

    logic [LIM_W-1:0] sq_sum;

    // Squared distance over the channels in use; the absolute difference keeps it unsigned.
    always_comb
    begin
        chan_t               ad;
        logic [2*CHAN_W-1:0] sq;
        sq_sum = '0;
        for (int c = 0; c < USED_CH; c++)
        begin
            ad     = (smp[c] >= pick[c]) ? chan_t'(smp[c] - pick[c]) : chan_t'(pick[c] - smp[c]);
            sq     = ad * ad;
            sq_sum = sq_sum + LIM_W'(sq);
        end
    end

    assign hit = in_range && (sq_sum < lim);
endmodule

>>> src/cbp_div.sv
`timescale 1ns / 1ps
module cbp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbp_pkg::DIV_W-1:0] dividend,
    input  logic [cbp_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [cbp_pkg::DIV_W-1:0] quotient,
    output logic [cbp_pkg::CNT_W-1:0] remainder
);
    import cbp_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg, q_next;
    logic [CNT_W:0]    r_reg, r_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    // One restoring step a cycle: bring in the next dividend bit, subtract if it fits.
    assign trial = {r_reg[CNT_W-1:0], q_reg[DIV_W-1]};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            step_next = STEP_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[CNT_W-1:0];
endmodule
